// ----- src/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and the operator precedence function for
// the infix-to-postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

	// Operator stack geometry
	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// Character codes
	localparam logic [7:0] CH_POW   = 8'h5E; // '^'
	localparam logic [7:0] CH_MUL   = 8'h2A; // '*'
	localparam logic [7:0] CH_DIV   = 8'h2F; // '/'
	localparam logic [7:0] CH_ADD   = 8'h2B; // '+'
	localparam logic [7:0] CH_SUB   = 8'h2D; // '-'
	localparam logic [7:0] CH_OPEN  = 8'h28; // '('
	localparam logic [7:0] CH_CLOSE = 8'h29; // ')'
	localparam logic [7:0] CH_NL    = 8'h0A; // newline
	localparam logic [7:0] CH_NONE  = 8'h00;

	// Result status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_UNM = 2'd2;

	// Character class decided by the front end
	typedef enum logic [2:0] {
		CLS_OPND  = 3'd0,
		CLS_NL    = 3'd1,
		CLS_OPER  = 3'd2,
		CLS_OPEN  = 3'd3,
		CLS_CLOSE = 3'd4
	} cls_t;

	// Precedence rank, lower binds tighter
	typedef logic [2:0] rank_t;

	// One classified request in the queue
	typedef struct packed {
		cls_t       cls;
		logic [7:0] ch;
		logic       fin;
	} item_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	function automatic rank_t rank_of(input logic [7:0] ch);
		rank_t r;
		unique case (ch)
			CH_POW:         r = 3'd1;
			CH_MUL, CH_DIV: r = 3'd2;
			CH_ADD, CH_SUB: r = 3'd3;
			CH_OPEN:        r = 3'd4;
			default:        r = 3'd5;
		endcase
		return r;
	endfunction

	function automatic cls_t classify(input logic [7:0] ch);
		cls_t c;
		unique case (ch)
			CH_NL:                                  c = CLS_NL;
			CH_OPEN:                                c = CLS_OPEN;
			CH_CLOSE:                               c = CLS_CLOSE;
			CH_POW, CH_MUL, CH_DIV, CH_ADD, CH_SUB: c = CLS_OPER;
			default:                                c = CLS_OPND;
		endcase
		return c;
	endfunction

endpackage

// ----- src/itp_front.sv -----
// ----------------------------------------------------------------------------
// itp_front
// Accepts input characters, classifies them and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module itp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [7:0]       in_char,
	input  logic             end_of_expr,
	output itp_pkg::head_t   head,
	input  logic             deq
);

	itp_pkg::item_t q_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           enq;

	// Stall only when both entries are taken
	assign req_stall = (cnt_q == 2'd2);
	assign enq       = req_valid && !req_stall;

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = q_q[rd_ptr_q];

	// Store the classified request
	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wr_ptr_q].cls <= itp_pkg::classify(in_char);
			q_q[wr_ptr_q].ch  <= in_char;
			q_q[wr_ptr_q].fin <= end_of_expr;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) wr_ptr_q <= !wr_ptr_q;
			if (deq) rd_ptr_q <= !rd_ptr_q;
			unique case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- src/itp_back.sv -----
// ----------------------------------------------------------------------------
// itp_back
// Runs the shunting-yard steps on the operator stack, one push or pop per
// cycle while the result port is not stalled, and drives the registered result port.
// ----------------------------------------------------------------------------
module itp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  itp_pkg::head_t  head,
	output logic            deq,
	output logic            res_valid,
	input  logic            res_stall,
	output logic [7:0]      out_char,
	output logic            last_of_run,
	output logic            expr_done,
	output logic [1:0]      status
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_OPER  = 6'b000010,
		S_CLOSE = 6'b000100,
		S_FLUSH = 6'b001000,
		S_DONE  = 6'b010000,
		S_SPARE = 6'b100000
	} state_t;

	state_t                     state_q, state_d;
	logic [7:0]                 cur_ch_q;
	logic                       cur_fin_q;
	logic [itp_pkg::CNT_W-1:0]  count_q;
	logic [7:0]                 mem_q [itp_pkg::STACK_DEPTH];
	logic [7:0]                 rd_q;
	logic [7:0]                 top_q;
	logic                       pop_q;
	logic [7:0]                 eff_top;
	logic [itp_pkg::CNT_W-1:0]  rd_idx;
	logic [itp_pkg::ADDR_W-1:0] rd_addr;
	logic                       full;
	logic                       advance;
	logic                       fin_d;

	// Pending result, held back until it is known whether it ends the run
	logic                       pend_v_q;
	logic [7:0]                 pend_ch_q;
	logic [1:0]                 pend_st_q;

	// Step controls
	logic                       gen;
	logic [7:0]                 gen_ch;
	logic [1:0]                 gen_st;
	logic                       push;
	logic                       pop;
	logic [7:0]                 push_ch;

	logic                       res_valid_q;
	logic [7:0]                 res_ch_q;
	logic                       res_last_q;
	logic                       res_done_q;
	logic [1:0]                 res_st_q;

	assign advance = !res_valid_q || !res_stall;
	assign full    = (count_q == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
	assign eff_top = pop_q ? rd_q : top_q;
	assign rd_idx  = count_q - itp_pkg::CNT_W'(2);
	assign rd_addr = rd_idx[itp_pkg::ADDR_W-1:0];
	assign fin_d   = (state_q == S_IDLE) ? head.item.fin : cur_fin_q;

	// Decide this cycle's step
	always_comb begin
		state_d = state_q;
		deq     = 1'b0;
		gen     = 1'b0;
		gen_ch  = itp_pkg::CH_NONE;
		gen_st  = itp_pkg::ST_OK;
		push    = 1'b0;
		pop     = 1'b0;
		push_ch = head.item.ch;
		if (advance) begin
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						deq = 1'b1;
						unique case (head.item.cls)
							itp_pkg::CLS_OPND: begin
								gen     = 1'b1;
								gen_ch  = head.item.ch;
								state_d = head.item.fin ? S_FLUSH : S_DONE;
							end
							itp_pkg::CLS_OPEN: begin
								if (full) begin
									gen    = 1'b1;
									gen_st = itp_pkg::ST_OVF;
								end else begin
									push = 1'b1;
								end
								state_d = head.item.fin ? S_FLUSH : S_DONE;
							end
							itp_pkg::CLS_OPER:  state_d = S_OPER;
							itp_pkg::CLS_CLOSE: state_d = S_CLOSE;
							default:            state_d = head.item.fin ? S_FLUSH : S_DONE;
						endcase
					end
				end
				S_OPER: begin
					push_ch = cur_ch_q;
					if (count_q != '0 &&
					    itp_pkg::rank_of(eff_top) <= itp_pkg::rank_of(cur_ch_q)) begin
						gen    = 1'b1;
						gen_ch = eff_top;
						pop    = 1'b1;
					end else begin
						if (full) begin
							gen    = 1'b1;
							gen_st = itp_pkg::ST_OVF;
						end else begin
							push = 1'b1;
						end
						state_d = cur_fin_q ? S_FLUSH : S_DONE;
					end
				end
				S_CLOSE: begin
					if (count_q == '0) begin
						gen     = 1'b1;
						gen_st  = itp_pkg::ST_UNM;
						state_d = cur_fin_q ? S_FLUSH : S_DONE;
					end else begin
						pop = 1'b1;
						if (eff_top == itp_pkg::CH_OPEN) begin
							state_d = cur_fin_q ? S_FLUSH : S_DONE;
						end else begin
							gen    = 1'b1;
							gen_ch = eff_top;
						end
					end
				end
				S_FLUSH: begin
					if (count_q == '0) begin
						state_d = S_DONE;
					end else begin
						gen    = 1'b1;
						gen_ch = eff_top;
						pop    = 1'b1;
					end
				end
				S_DONE:  state_d = S_IDLE;
				default: state_d = S_IDLE;
			endcase
		end
	end

	// Stack memory with registered read of the entry below the top
	always_ff @(posedge clk) begin
		if (push) mem_q[count_q[itp_pkg::ADDR_W-1:0]] <= push_ch;
		rd_q  <= mem_q[rd_addr];
		top_q <= push ? push_ch : eff_top;
	end

	// Latch the request being worked on
	always_ff @(posedge clk) begin
		if (deq) begin
			cur_ch_q  <= head.item.ch;
			cur_fin_q <= head.item.fin;
		end
	end

	// Hold pending and output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			if (gen) begin
				pend_ch_q <= gen_ch;
				pend_st_q <= gen_st;
				res_ch_q   <= pend_ch_q;
				res_st_q   <= pend_st_q;
				res_last_q <= 1'b0;
				res_done_q <= 1'b0;
			end else if (state_q == S_DONE) begin
				res_ch_q   <= pend_v_q ? pend_ch_q : itp_pkg::CH_NONE;
				res_st_q   <= pend_v_q ? pend_st_q : itp_pkg::ST_OK;
				res_last_q <= 1'b1;
				res_done_q <= fin_d;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pop_q       <= 1'b0;
			pend_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			pop_q <= pop;
			if (advance) begin
				state_q     <= state_d;
				res_valid_q <= 1'b0;
				if (push) count_q <= count_q + itp_pkg::CNT_W'(1);
				else if (pop) count_q <= count_q - itp_pkg::CNT_W'(1);
				if (gen) begin
					pend_v_q    <= 1'b1;
					res_valid_q <= pend_v_q;
				end else if (state_q == S_DONE) begin
					pend_v_q    <= 1'b0;
					res_valid_q <= pend_v_q || cur_fin_q;
				end
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign out_char    = res_ch_q;
	assign last_of_run = res_last_q;
	assign expr_done   = res_done_q;
	assign status      = res_st_q;

endmodule

// ----- src/infix_to_postfix_converter_core.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter: one infix character per request in, postfix
// characters out, with a front end that classifies and a back end that
// works the operator stack.
// ----------------------------------------------------------------------------
//  channel   valid      stall      payload
//  request   req_valid  req_stall  in_char, end_of_expr
//  result    res_valid  res_stall  out_char, last_of_run, expr_done, status
//
//  Each pop is its own step on the single stack port. Operand, newline, '(':
//  take, close; operator: take, pop what binds as tight or tighter, push,
//  close; ')': take, pop up to and including '(', report when unmatched,
//  close; end flush: pop every stacked entry, close. Reset clears the stack
//  count, queue and result register, with no clear pass. A stalled result
//  freezes the back end; the two-entry queue keeps taking requests till full.
module infix_to_postfix_converter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [7:0] in_char,
	input  logic       end_of_expr,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_char,
	output logic       last_of_run,
	output logic       expr_done,
	output logic [1:0] status
);

	itp_pkg::head_t head;
	logic           deq;

	itp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.in_char     (in_char),
		.end_of_expr (end_of_expr),
		.head        (head),
		.deq         (deq)
	);

	itp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.deq         (deq),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_char    (out_char),
		.last_of_run (last_of_run),
		.expr_done   (expr_done),
		.status      (status)
	);

	// An error result carries no character
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != itp_pkg::ST_OK |-> out_char == itp_pkg::CH_NONE)
		else $error("error result with non-zero character");

	// The end of an expression is always the end of a run
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && expr_done |-> last_of_run)
		else $error("expression done without last of run");

	// An unmatched close paren empties the stack, so nothing follows it
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == itp_pkg::ST_UNM |-> last_of_run)
		else $error("unmatched paren result not last of run");

	// The back end only takes a request from a non-empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> head.valid)
		else $error("dequeue from empty queue");

endmodule

// ----- sim/infix_to_postfix_converter_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core_tb
// Feeds infix characters into the converter and checks every postfix
// result, field by field, against an in-bench shunting-yard predictor.
// Directed expressions and error cases run first. Random well-formed
// expressions follow, mixed with noise, stray parens and deep nesting that
// overflows the operator stack. Requests idle and results stall at random.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core_tb;

	localparam int RANDOM_ITEMS = 124;
	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 80;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} request_t;

	typedef struct {
		logic [7:0] out_char;
		logic       last_of_run;
		logic       expr_done;
		logic [1:0] status;
	} postfix_res_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       req_valid   = 1'b0;
	logic       req_stall;
	logic [7:0] in_char     = itp_pkg::CH_NONE;
	logic       end_of_expr = 1'b0;
	logic       res_valid;
	logic       res_stall   = 1'b0;
	logic [7:0] out_char;
	logic       last_of_run;
	logic       expr_done;
	logic [1:0] status;

	// Stimulus and expectations
	request_t     request_q[$];
	int           drain_at[$];
	postfix_res_t postfix_q[$];
	logic         drained = 1'b1;

	// Predictor state
	logic [7:0] op_stack [itp_pkg::STACK_DEPTH];
	int         op_depth;

	int           next_index;
	int           burst_left;
	int           gap_left;
	int           stall_left;
	int           free_left;
	int           idle_cycles;
	int           mismatches;
	int           stim_count;
	postfix_res_t want;

	infix_to_postfix_converter_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.in_char     (in_char),
		.end_of_expr (end_of_expr),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_char    (out_char),
		.last_of_run (last_of_run),
		.expr_done   (expr_done),
		.status      (status)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Binding strength: lower binds tighter, 5 for anything that is not stacked
	function automatic int bind_level(input logic [7:0] ch);
		case (ch)
			itp_pkg::CH_POW:                  return 1;
			itp_pkg::CH_MUL, itp_pkg::CH_DIV: return 2;
			itp_pkg::CH_ADD, itp_pkg::CH_SUB: return 3;
			itp_pkg::CH_OPEN:                 return 4;
			default:                          return 5;
		endcase
	endfunction

	function automatic postfix_res_t make_res(input logic [7:0] ch, input logic [1:0] st);
		postfix_res_t r;
		r.out_char    = ch;
		r.last_of_run = 1'b0;
		r.expr_done   = 1'b0;
		r.status      = st;
		return r;
	endfunction

	// Work out the postfix results of one accepted request
	task automatic convert_char(input logic [7:0] ch, input logic fin);
		postfix_res_t run_q[$];
		postfix_res_t tail;
		logic [7:0]   top;
		bit           matched;
		matched = 1'b0;
		if (ch == itp_pkg::CH_NL) begin
			// newline: nothing to do
		end else if (ch == itp_pkg::CH_CLOSE) begin
			while (op_depth > 0 && !matched) begin
				op_depth--;
				top = op_stack[op_depth];
				if (top == itp_pkg::CH_OPEN)
					matched = 1'b1;
				else
					run_q.push_back(make_res(top, itp_pkg::ST_OK));
			end
			if (!matched)
				run_q.push_back(make_res(itp_pkg::CH_NONE, itp_pkg::ST_UNM));
		end else if (bind_level(ch) <= 4) begin
			// operators first pop everything that binds as tight or tighter
			if (ch != itp_pkg::CH_OPEN) begin
				while (op_depth > 0 &&
					bind_level(op_stack[op_depth - 1]) <= bind_level(ch)) begin
					op_depth--;
					run_q.push_back(make_res(op_stack[op_depth], itp_pkg::ST_OK));
				end
			end
			if (op_depth < itp_pkg::STACK_DEPTH) begin
				op_stack[op_depth] = ch;
				op_depth++;
			end else begin
				run_q.push_back(make_res(itp_pkg::CH_NONE, itp_pkg::ST_OVF));
			end
		end else begin
			run_q.push_back(make_res(ch, itp_pkg::ST_OK));
		end
		// flush the whole stack at the end of an expression
		if (fin) begin
			while (op_depth > 0) begin
				op_depth--;
				run_q.push_back(make_res(op_stack[op_depth], itp_pkg::ST_OK));
			end
			if (run_q.size() == 0)
				run_q.push_back(make_res(itp_pkg::CH_NONE, itp_pkg::ST_OK));
		end
		if (run_q.size() > 0) begin
			tail = run_q.pop_back();
			tail.last_of_run = 1'b1;
			tail.expr_done   = fin;
			run_q.push_back(tail);
		end
		foreach (run_q[i])
			postfix_q.push_back(run_q[i]);
	endtask

	task automatic add_req(input logic [7:0] ch, input logic fin);
		request_t r;
		r.ch  = ch;
		r.fin = fin;
		request_q.push_back(r);
		if (ch != itp_pkg::CH_NL)
			stim_count++;
	endtask

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 4))
			0:       return itp_pkg::CH_POW;
			1:       return itp_pkg::CH_MUL;
			2:       return itp_pkg::CH_DIV;
			3:       return itp_pkg::CH_ADD;
			default: return itp_pkg::CH_SUB;
		endcase
	endfunction

	function automatic logic [7:0] pick_operand();
		case ($urandom_range(0, 4))
			0:       return 8'($urandom_range(0, 255));
			1:       return 8'("0" + $urandom_range(0, 9));
			2:       return 8'("A" + $urandom_range(0, 25));
			default: return 8'("a" + $urandom_range(0, 25));
		endcase
	endfunction

	// Nest open parens, then an operator that may find the stack full
	task automatic add_deep_nesting(input int levels);
		for (int i = 0; i < levels; i++)
			add_req(itp_pkg::CH_OPEN, 1'b0);
		add_req(pick_operand(), 1'b0);
		add_req(pick_operator(), 1'b0);
		add_req(pick_operand(), 1'b1);
	endtask

	// One random expression, mostly well formed, with some noise
	task automatic add_expression();
		request_t last;
		int       n_opnd;
		int       depth;
		n_opnd = $urandom_range(1, 8);
		depth  = 0;
		for (int k = 0; k < n_opnd; k++) begin
			while (depth < 6 && $urandom_range(0, 3) == 0) begin
				add_req(itp_pkg::CH_OPEN, 1'b0);
				depth++;
			end
			add_req(pick_operand(), 1'b0);
			while (depth > 0 && $urandom_range(0, 2) == 0) begin
				add_req(itp_pkg::CH_CLOSE, 1'b0);
				depth--;
			end
			case ($urandom_range(0, 15))
				0:       add_req(8'($urandom_range(0, 255)), 1'b0);
				1:       add_req(itp_pkg::CH_CLOSE, 1'b0);
				2:       add_req(itp_pkg::CH_NL, 1'b0);
				default: ;
			endcase
			if (k < n_opnd - 1)
				add_req(pick_operator(), 1'b0);
		end
		while (depth > 0 && $urandom_range(0, 4) != 0) begin
			add_req(itp_pkg::CH_CLOSE, 1'b0);
			depth--;
		end
		// end on a trailing newline now and then, else on the last character
		if ($urandom_range(0, 5) == 0) begin
			add_req(itp_pkg::CH_NL, 1'b1);
		end else begin
			last = request_q.pop_back();
			last.fin = 1'b1;
			request_q.push_back(last);
		end
	endtask

	// Request driver: bursts with gaps, holds a stalled request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid   <= 1'b0;
			in_char     <= itp_pkg::CH_NONE;
			end_of_expr <= 1'b0;
			next_index  = 0;
			burst_left  = 0;
			gap_left    = 0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid) begin
				void'(request_q.pop_front());
				next_index++;
			end
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (request_q.size() == 0) begin
				req_valid <= 1'b0;
			end else if (drain_at.size() > 0 && drain_at[0] == next_index
				&& !(!req_valid && drained)) begin
				// hold off until every expected result has come out
				req_valid <= 1'b0;
			end else begin
				if (drain_at.size() > 0 && drain_at[0] == next_index)
					void'(drain_at.pop_front());
				req_valid   <= 1'b1;
				in_char     <= request_q[0].ch;
				end_of_expr <= request_q[0].fin;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
		end
	end

	// Result monitor: check, predict, stall pattern and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall   <= 1'b0;
			drained     <= 1'b1;
			op_depth    = 0;
			stall_left  = 0;
			free_left   = 0;
			idle_cycles = 0;
		end else begin
			// check the result taken at this edge against the oldest prediction
			if (res_valid && !res_stall) begin
				if (postfix_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: char %h last %b done %b status %0d",
							out_char, last_of_run, expr_done, status);
				end else begin
					want = postfix_q.pop_front();
					if (out_char !== want.out_char || last_of_run !== want.last_of_run
						|| expr_done !== want.expr_done || status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
								want.out_char, want.last_of_run, want.expr_done,
								want.status, out_char, last_of_run, expr_done, status);
					end
				end
			end

			if (req_valid && !req_stall)
				convert_char(in_char, end_of_expr);
			drained <= (postfix_q.size() == 0);

			// stall in runs: none, short or long
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				res_stall <= 1'b0;
			end else begin
				free_left = $urandom_range(0, 40);
				case ($urandom_range(0, 3))
					0:       stall_left = 0;
					1:       stall_left = $urandom_range(10, 30);
					default: stall_left = $urandom_range(1, 4);
				endcase
				res_stall <= 1'b0;
			end

			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		mismatches = 0;
		stim_count = 0;

		// directed: precedence, parens, error cases, end marker, extreme bytes
		add_req("a", 1'b0);
		add_req(itp_pkg::CH_ADD, 1'b0);
		add_req("b", 1'b0);
		add_req(itp_pkg::CH_MUL, 1'b0);
		add_req("c", 1'b1);
		add_req(itp_pkg::CH_OPEN, 1'b0);
		add_req("a", 1'b0);
		add_req(itp_pkg::CH_SUB, 1'b0);
		add_req("b", 1'b0);
		add_req(itp_pkg::CH_CLOSE, 1'b0);
		add_req(itp_pkg::CH_POW, 1'b0);
		add_req("c", 1'b0);
		add_req(itp_pkg::CH_DIV, 1'b0);
		add_req("d", 1'b1);
		add_req(itp_pkg::CH_CLOSE, 1'b1);
		add_req("x", 1'b0);
		add_req(itp_pkg::CH_ADD, 1'b0);
		add_req(itp_pkg::CH_CLOSE, 1'b0);
		add_req(itp_pkg::CH_NL, 1'b0);
		add_req(itp_pkg::CH_NL, 1'b1);
		add_req(itp_pkg::CH_OPEN, 1'b1);
		add_req(8'h00, 1'b0);
		add_req(8'h80, 1'b0);
		add_req(8'hFF, 1'b1);

		// random: start after a full drain with a stack overflow
		drain_at.push_back(request_q.size());
		stim_count = 0;
		add_deep_nesting(itp_pkg::STACK_DEPTH + 2);
		while (stim_count < RANDOM_ITEMS) begin
			if (stim_count >= RANDOM_ITEMS / 2 && drain_at.size() < 2)
				drain_at.push_back(request_q.size());
			if ($urandom_range(0, 11) == 0)
				add_deep_nesting($urandom_range(itp_pkg::STACK_DEPTH - 3,
					itp_pkg::STACK_DEPTH + 3));
			else
				add_expression();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every request to go in and every result to come out
		while (request_q.size() != 0 || postfix_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && postfix_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
